// ----- hdl/gtsc_pkg.sv -----
// Shared types, constants and helpers for the gyro turn speed controller.
package gtsc_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_MIN_TURN_SPEED = 2'd0;
   localparam logic [1:0] CSR_SLOW_ZONE      = 2'd1;
   localparam logic [1:0] CSR_STOP_BAND      = 2'd2;
   localparam logic [1:0] CSR_TIMEOUT_MS     = 2'd3;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // Configuration reset values
   localparam logic [7:0]  RST_MIN_TURN_SPEED = 8'd40;
   localparam logic [14:0] RST_SLOW_ZONE      = 15'd3000;
   localparam logic [14:0] RST_STOP_BAND      = 15'd100;
   localparam logic [15:0] RST_TIMEOUT_MS     = 16'd5000;

   // Command codes
   localparam logic CMD_START = 1'b0;

   // Result status codes
   localparam logic [2:0] ST_STARTED   = 3'd0;
   localparam logic [2:0] ST_BAD_SPEED = 3'd1;
   localparam logic [2:0] ST_BAD_ANGLE = 3'd2;
   localparam logic [2:0] ST_DRIVING   = 3'd3;
   localparam logic [2:0] ST_REACHED   = 3'd4;
   localparam logic [2:0] ST_OVERSHOOT = 3'd5;
   localparam logic [2:0] ST_TIMEOUT   = 3'd6;
   localparam logic [2:0] ST_IDLE      = 3'd7;

   // Angle wrapping, centidegrees
   localparam logic signed [17:0] HALF_TURN_CD = 18'sd18000;
   localparam logic signed [17:0] FULL_TURN_CD = 18'sd36000;
   localparam int WRAP_STEPS = 2;

   // Speed profile quotient width (the quotient is always below the 8-bit span)
   localparam int QUOT_W = 8;

   localparam int DEF_QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [7:0]  min_turn_speed;
      logic [14:0] slow_zone;
      logic [14:0] stop_band;
      logic [15:0] timeout_ms;
   } cfg_type;

   typedef enum logic [1:0] {
      KIND_START,
      KIND_BAD_SPEED,
      KIND_BAD_ANGLE,
      KIND_SAMPLE
   } kind_type;

   // Classified transaction as passed from front to back
   typedef struct packed {
      kind_type           kind;
      logic               dir_right;
      logic [7:0]         speed;
      logic signed [15:0] yaw;
      logic signed [15:0] target;
      logic [31:0]        now_ms;
   } item_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_EVAL,
      BK_SQUARE,
      BK_SCALE,
      BK_DIVIDE,
      BK_SEND
   } back_state_type;

   function automatic logic signed [17:0] sx18(input logic signed [15:0] a);
      return {{2{a[15]}}, a};
   endfunction

   // Wrap into +/-18000; inputs stay within two turns of the range
   function automatic logic signed [15:0] wrap_cd(input logic signed [17:0] a);
      logic signed [17:0] v;
      v = a;
      for (int i = 0; i < WRAP_STEPS; i++) begin
         if (v > HALF_TURN_CD) begin
            v = v - FULL_TURN_CD;
         end else if (v < -HALF_TURN_CD) begin
            v = v + FULL_TURN_CD;
         end
      end
      return v[15:0];
   endfunction

   // Magnitude of a wrapped angle
   function automatic logic [14:0] abs_cd(input logic signed [15:0] a);
      logic signed [15:0] n;
      n = -a;
      return a[15] ? n[14:0] : a[14:0];
   endfunction

endpackage

// ----- hdl/gyro_turn_speed_controller.sv -----
// Top level of the gyro turn speed controller: config registers, front, queue, back.
//
// Drives a differential-drive turn from gyro yaw readings in centidegrees. A start
// transaction (cmd 0) is checked for a nonzero speed and angle and latches the start
// yaw, target yaw, initial error and timestamp; each yaw sample (cmd 1) returns one
// response with the wheel drives or, at the stop band, on an error sign flip or on
// timeout, the angle turned and elapsed time. The front classifies and wraps each
// request and hands it to a queue of QUEUE_DEPTH entries, so requests keep being
// taken, until the queue fills, while the back works or while a response waits for
// rsp_ready. The back handles one transaction at a time: dequeue, evaluate and
// present for starts, rejects, idle samples, stops and full or floor speed
// samples; a driving sample inside the slow zone also passes two multiply stages
// and an 8-step restoring divider for the quadratic speed profile. The csr port
// is always ready; write it only while no transaction is outstanding.
module gyro_turn_speed_controller #(
   parameter int QUEUE_DEPTH = gtsc_pkg::DEF_QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_cmd,
   input  logic                              req_turn_dir,
   input  logic [7:0]                        req_speed,
   input  logic [15:0]                       req_turn_angle,
   input  logic signed [15:0]                req_yaw,
   input  logic [31:0]                       req_now_ms,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [2:0]                        rsp_status,
   output logic signed [8:0]                 rsp_left_drive,
   output logic signed [8:0]                 rsp_right_drive,
   output logic [14:0]                       rsp_swept_angle,
   output logic [31:0]                       rsp_time_taken,
   // configuration write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gtsc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [gtsc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   gtsc_pkg::cfg_type  cfg_ff, cfg_in;
   gtsc_pkg::item_type push_item, pop_item;
   logic               push_valid, push_ready;
   logic               pop_valid, pop_ready;

   // config writes are always accepted and registered
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            gtsc_pkg::CSR_MIN_TURN_SPEED: cfg_in.min_turn_speed = csr_wdata[7:0];
            gtsc_pkg::CSR_SLOW_ZONE:      cfg_in.slow_zone      = csr_wdata[14:0];
            gtsc_pkg::CSR_STOP_BAND:      cfg_in.stop_band      = csr_wdata[14:0];
            gtsc_pkg::CSR_TIMEOUT_MS:     cfg_in.timeout_ms     = csr_wdata[15:0];
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_turn_speed <= gtsc_pkg::RST_MIN_TURN_SPEED;
         cfg_ff.slow_zone      <= gtsc_pkg::RST_SLOW_ZONE;
         cfg_ff.stop_band      <= gtsc_pkg::RST_STOP_BAND;
         cfg_ff.timeout_ms     <= gtsc_pkg::RST_TIMEOUT_MS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // classify and wrap incoming transactions
   gtsc_front u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_turn_dir   (req_turn_dir),
      .req_speed      (req_speed),
      .req_turn_angle (req_turn_angle),
      .req_yaw        (req_yaw),
      .req_now_ms     (req_now_ms),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_item      (push_item)
   );

   // decouples front from back
   gtsc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // turn state, stop tests, speed profile, response register
   gtsc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_item         (pop_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_left_drive   (rsp_left_drive),
      .rsp_right_drive  (rsp_right_drive),
      .rsp_swept_angle  (rsp_swept_angle),
      .rsp_time_taken   (rsp_time_taken)
   );

endmodule

// ----- hdl/gtsc_front.sv -----
// Front end: takes request transactions, wraps the yaw and classifies them.
module gtsc_front (
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_cmd,
   input  logic               req_turn_dir,
   input  logic [7:0]         req_speed,
   input  logic [15:0]        req_turn_angle,
   input  logic signed [15:0] req_yaw,
   input  logic [31:0]        req_now_ms,
   output logic               push_valid,
   input  logic               push_ready,
   output gtsc_pkg::item_type push_item
);

   logic signed [15:0] yaw_w;
   logic signed [17:0] ang_ext;
   logic signed [17:0] target_raw;

   assign yaw_w      = gtsc_pkg::wrap_cd(gtsc_pkg::sx18(req_yaw));
   assign ang_ext    = $signed({2'b00, req_turn_angle});
   assign target_raw = req_turn_dir ? gtsc_pkg::sx18(yaw_w) - ang_ext
                                    : gtsc_pkg::sx18(yaw_w) + ang_ext;

   assign push_valid = req_valid;
   assign req_ready  = push_ready;

   always_comb begin
      push_item.dir_right = req_turn_dir;
      push_item.speed     = req_speed;
      push_item.yaw       = yaw_w;
      push_item.target    = gtsc_pkg::wrap_cd(target_raw);
      push_item.now_ms    = req_now_ms;
      if (req_cmd != gtsc_pkg::CMD_START) begin
         push_item.kind = gtsc_pkg::KIND_SAMPLE;
      end else if (req_speed == 8'd0) begin
         push_item.kind = gtsc_pkg::KIND_BAD_SPEED;
      end else if (req_turn_angle == 16'd0) begin
         push_item.kind = gtsc_pkg::KIND_BAD_ANGLE;
      end else begin
         push_item.kind = gtsc_pkg::KIND_START;
      end
   end

endmodule

// ----- hdl/gtsc_queue.sv -----
// Small FIFO of classified transactions between front and back.
module gtsc_queue #(
   parameter int DEPTH = gtsc_pkg::DEF_QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  gtsc_pkg::item_type push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output gtsc_pkg::item_type pop_item
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

   gtsc_pkg::item_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign push_ready = (count_ff != FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- hdl/gtsc_back.sv -----
// Back end: turn state, stop tests, speed profile and the response register.
module gtsc_back (
   input  logic               clock,
   input  logic               reset,
   input  gtsc_pkg::cfg_type  cfg,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  gtsc_pkg::item_type pop_item,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic signed [8:0]  rsp_left_drive,
   output logic signed [8:0]  rsp_right_drive,
   output logic [14:0]        rsp_swept_angle,
   output logic [31:0]        rsp_time_taken
);

   localparam int QW    = gtsc_pkg::QUOT_W;
   localparam int SQ_W  = 30;
   localparam int NUM_W = SQ_W + QW;
   localparam int CNT_W = $clog2(QW);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QW - 1);

   gtsc_pkg::back_state_type state_ff, state_in;
   gtsc_pkg::item_type cur_ff, cur_in;

   logic               turning_ff, turning_in;
   logic               dir_right_ff, dir_right_in;
   logic [7:0]         top_speed_ff, top_speed_in;
   logic signed [15:0] start_yaw_ff, start_yaw_in;
   logic signed [15:0] target_yaw_ff, target_yaw_in;
   logic signed [15:0] prev_error_ff, prev_error_in;
   logic [31:0]        start_ms_ff, start_ms_in;

   logic [14:0]        e_ff, e_in;
   logic [7:0]         span_ff, span_in;
   logic [SQ_W-1:0]    esq_ff, esq_in;
   logic [NUM_W-1:0]   rem_ff, rem_in;
   logic [NUM_W-1:0]   div_ff, div_in;
   logic [QW-1:0]      quot_ff, quot_in;
   logic [CNT_W-1:0]   step_ff, step_in;

   logic [2:0]         status_ff, status_in;
   logic signed [8:0]  left_ff, left_in;
   logic signed [8:0]  right_ff, right_in;
   logic [14:0]        angle_ff, angle_in;
   logic [31:0]        time_ff, time_in;

   // Evaluation of the current transaction
   logic signed [15:0] err;
   logic [14:0]        e_cur;
   logic [31:0]        elapsed;
   logic [2:0]         sample_status;
   logic               prev_pos, prev_neg, err_pos, err_neg;
   logic               slow_needed;
   logic [SQ_W-1:0]    e_sq;
   logic [SQ_W-1:0]    sz_sq;
   logic [NUM_W-1:0]   scaled;
   logic               fits;
   logic [7:0]         speed_div;

   function automatic logic signed [8:0] neg_drive(input logic [7:0] s);
      logic signed [8:0] p;
      p = $signed({1'b0, s});
      return -p;
   endfunction

   function automatic logic signed [8:0] pos_drive(input logic [7:0] s);
      return $signed({1'b0, s});
   endfunction

   assign err     = gtsc_pkg::wrap_cd(gtsc_pkg::sx18(target_yaw_ff)
                                      - gtsc_pkg::sx18(cur_ff.yaw));
   assign e_cur   = gtsc_pkg::abs_cd(err);
   assign elapsed = cur_ff.now_ms - start_ms_ff;

   assign prev_pos = !prev_error_ff[15] && (prev_error_ff != 16'sd0);
   assign prev_neg = prev_error_ff[15];
   assign err_pos  = !err[15] && (err != 16'sd0);
   assign err_neg  = err[15];

   always_comb begin
      if (e_cur <= cfg.stop_band) begin
         sample_status = gtsc_pkg::ST_REACHED;
      end else if ((prev_pos && err_neg) || (prev_neg && err_pos)) begin
         sample_status = gtsc_pkg::ST_OVERSHOOT;
      end else if (elapsed > {16'd0, cfg.timeout_ms}) begin
         sample_status = gtsc_pkg::ST_TIMEOUT;
      end else begin
         sample_status = gtsc_pkg::ST_DRIVING;
      end
   end

   // Profile only matters below the slow zone and with a top speed above the floor
   assign slow_needed = (top_speed_ff > cfg.min_turn_speed) && (cfg.slow_zone != 15'd0)
                        && (e_cur < cfg.slow_zone);

   assign e_sq   = {{(SQ_W-15){1'b0}}, e_ff} * {{(SQ_W-15){1'b0}}, e_ff};
   assign sz_sq  = {{(SQ_W-15){1'b0}}, cfg.slow_zone} * {{(SQ_W-15){1'b0}}, cfg.slow_zone};
   assign scaled = {{QW{1'b0}}, esq_ff} * {{SQ_W{1'b0}}, span_ff};
   assign fits   = (rem_ff >= div_ff);
   assign speed_div = cfg.min_turn_speed + quot_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gtsc_pkg::BK_IDLE: begin
            if (pop_valid) state_in = gtsc_pkg::BK_EVAL;
         end
         gtsc_pkg::BK_EVAL: begin
            if (cur_ff.kind == gtsc_pkg::KIND_SAMPLE && turning_ff
                && sample_status == gtsc_pkg::ST_DRIVING && slow_needed) begin
               state_in = gtsc_pkg::BK_SQUARE;
            end else begin
               state_in = gtsc_pkg::BK_SEND;
            end
         end
         gtsc_pkg::BK_SQUARE: state_in = gtsc_pkg::BK_SCALE;
         gtsc_pkg::BK_SCALE:  state_in = gtsc_pkg::BK_DIVIDE;
         gtsc_pkg::BK_DIVIDE: begin
            if (step_ff == LAST_STEP) state_in = gtsc_pkg::BK_SEND;
         end
         gtsc_pkg::BK_SEND: begin
            if (rsp_ready) state_in = gtsc_pkg::BK_IDLE;
         end
         default: state_in = gtsc_pkg::BK_IDLE;
      endcase
   end

   // Handshake outputs
   always_comb begin
      pop_ready = (state_ff == gtsc_pkg::BK_IDLE);
      rsp_valid = (state_ff == gtsc_pkg::BK_SEND);
   end

   assign rsp_status      = status_ff;
   assign rsp_left_drive  = left_ff;
   assign rsp_right_drive = right_ff;
   assign rsp_swept_angle = angle_ff;
   assign rsp_time_taken  = time_ff;

   // Datapath
   always_comb begin
      cur_in        = cur_ff;
      turning_in    = turning_ff;
      dir_right_in  = dir_right_ff;
      top_speed_in  = top_speed_ff;
      start_yaw_in  = start_yaw_ff;
      target_yaw_in = target_yaw_ff;
      prev_error_in = prev_error_ff;
      start_ms_in   = start_ms_ff;
      e_in          = e_ff;
      span_in       = span_ff;
      esq_in        = esq_ff;
      rem_in        = rem_ff;
      div_in        = div_ff;
      quot_in       = quot_ff;
      step_in       = step_ff;
      status_in     = status_ff;
      left_in       = left_ff;
      right_in      = right_ff;
      angle_in      = angle_ff;
      time_in       = time_ff;

      case (state_ff)
         gtsc_pkg::BK_IDLE: begin
            if (pop_valid) cur_in = pop_item;
         end
         gtsc_pkg::BK_EVAL: begin
            left_in  = 9'sd0;
            right_in = 9'sd0;
            angle_in = 15'd0;
            time_in  = 32'd0;
            case (cur_ff.kind)
               gtsc_pkg::KIND_BAD_SPEED: status_in = gtsc_pkg::ST_BAD_SPEED;
               gtsc_pkg::KIND_BAD_ANGLE: status_in = gtsc_pkg::ST_BAD_ANGLE;
               gtsc_pkg::KIND_START: begin
                  status_in     = gtsc_pkg::ST_STARTED;
                  turning_in    = 1'b1;
                  dir_right_in  = cur_ff.dir_right;
                  top_speed_in  = cur_ff.speed;
                  start_yaw_in  = cur_ff.yaw;
                  target_yaw_in = cur_ff.target;
                  prev_error_in = gtsc_pkg::wrap_cd(gtsc_pkg::sx18(cur_ff.target)
                                                    - gtsc_pkg::sx18(cur_ff.yaw));
                  start_ms_in   = cur_ff.now_ms;
               end
               gtsc_pkg::KIND_SAMPLE: begin
                  if (!turning_ff) begin
                     status_in = gtsc_pkg::ST_IDLE;
                  end else if (sample_status != gtsc_pkg::ST_DRIVING) begin
                     status_in  = sample_status;
                     turning_in = 1'b0;
                     angle_in   = gtsc_pkg::abs_cd(gtsc_pkg::wrap_cd(
                                     gtsc_pkg::sx18(cur_ff.yaw)
                                     - gtsc_pkg::sx18(start_yaw_ff)));
                     time_in    = elapsed;
                  end else begin
                     status_in     = gtsc_pkg::ST_DRIVING;
                     prev_error_in = err;
                     e_in          = e_cur;
                     span_in       = top_speed_ff - cfg.min_turn_speed;
                     if (!slow_needed) begin
                        // floor wins when top is at or below it, else full speed
                        if (top_speed_ff > cfg.min_turn_speed) begin
                           left_in  = dir_right_ff ? pos_drive(top_speed_ff)
                                                   : neg_drive(top_speed_ff);
                           right_in = dir_right_ff ? neg_drive(top_speed_ff)
                                                   : pos_drive(top_speed_ff);
                        end else begin
                           left_in  = dir_right_ff ? pos_drive(cfg.min_turn_speed)
                                                   : neg_drive(cfg.min_turn_speed);
                           right_in = dir_right_ff ? neg_drive(cfg.min_turn_speed)
                                                   : pos_drive(cfg.min_turn_speed);
                        end
                     end
                  end
               end
               default: status_in = gtsc_pkg::ST_IDLE;
            endcase
         end
         gtsc_pkg::BK_SQUARE: begin
            esq_in  = e_sq;
            div_in  = {sz_sq, {QW-1{1'b0}}, 1'b0} >> 1;
            quot_in = '0;
            step_in = '0;
         end
         gtsc_pkg::BK_SCALE: begin
            rem_in = scaled;
         end
         gtsc_pkg::BK_DIVIDE: begin
            // restoring division, one quotient bit per cycle, MSB first
            rem_in  = fits ? rem_ff - div_ff : rem_ff;
            div_in  = div_ff >> 1;
            quot_in = {quot_ff[QW-2:0], fits};
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               left_in  = dir_right_ff ? pos_drive(speed_div) : neg_drive(speed_div);
               right_in = dir_right_ff ? neg_drive(speed_div) : pos_drive(speed_div);
            end
         end
         gtsc_pkg::BK_SEND: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= gtsc_pkg::BK_IDLE;
         turning_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         turning_ff <= turning_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      dir_right_ff  <= dir_right_in;
      top_speed_ff  <= top_speed_in;
      start_yaw_ff  <= start_yaw_in;
      target_yaw_ff <= target_yaw_in;
      prev_error_ff <= prev_error_in;
      start_ms_ff   <= start_ms_in;
      e_ff          <= e_in;
      span_ff       <= span_in;
      esq_ff        <= esq_in;
      rem_ff        <= rem_in;
      div_ff        <= div_in;
      quot_ff       <= quot_in;
      step_ff       <= step_in;
      status_ff     <= status_in;
      left_ff       <= left_in;
      right_ff      <= right_in;
      angle_ff      <= angle_in;
      time_ff       <= time_in;
   end

endmodule

// ----- sim/gyro_turn_speed_controller_tb.sv -----
// Self-checking testbench for the gyro turn speed controller.
`timescale 1ns / 1ps

module gyro_turn_speed_controller_tb;

   // yaw sample command; the package only names the start code
   localparam logic CMD_YAW     = 1'b1;
   // cycles with no transaction on any channel before the run is abandoned
   localparam int   STALL_LIMIT = 2000;
   localparam int   RANDOM_ITEMS = 370;

   // one expected response, at the widths of the response ports
   typedef struct packed {
      logic [2:0]  status;
      logic [8:0]  left;
      logic [8:0]  right;
      logic [14:0] angle;
      logic [31:0] elapsed;
   } turn_outcome_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic                             req_cmd = 1'b0;
   logic                             req_turn_dir = 1'b0;
   logic [7:0]                       req_speed = '0;
   logic [15:0]                      req_turn_angle = '0;
   logic signed [15:0]               req_yaw = '0;
   logic [31:0]                      req_now_ms = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [2:0]                       rsp_status;
   logic signed [8:0]                rsp_left_drive;
   logic signed [8:0]                rsp_right_drive;
   logic [14:0]                      rsp_swept_angle;
   logic [31:0]                      rsp_time_taken;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [gtsc_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [gtsc_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   gyro_turn_speed_controller DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_turn_dir(req_turn_dir),
      .req_speed(req_speed),
      .req_turn_angle(req_turn_angle),
      .req_yaw(req_yaw),
      .req_now_ms(req_now_ms),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_left_drive(rsp_left_drive),
      .rsp_right_drive(rsp_right_drive),
      .rsp_swept_angle(rsp_swept_angle),
      .rsp_time_taken(rsp_time_taken),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Turn predictor: a private copy of the registers and turn state, moved
   // forward once per accepted request transaction.
   // ---------------------------------------------------------------------
   logic [7:0]  cf_min_speed = gtsc_pkg::RST_MIN_TURN_SPEED;
   logic [14:0] cf_slow_zone = gtsc_pkg::RST_SLOW_ZONE;
   logic [14:0] cf_stop_band = gtsc_pkg::RST_STOP_BAND;
   logic [15:0] cf_timeout   = gtsc_pkg::RST_TIMEOUT_MS;

   bit          pr_turning   = 1'b0;
   bit          pr_right     = 1'b0;
   int          pr_top       = 0;
   int          pr_start_yaw = 0;
   int          pr_target    = 0;
   int          pr_prev_err  = 0;
   logic [31:0] pr_start_ms  = '0;

   turn_outcome_type due_outcomes[$];

   // bookkeeping
   int  fail_count = 0;
   int  sent_count = 0;
   int  config_loads = 0;
   int  status_seen[8];
   int  quiet_cycles = 0;
   int  rsp_hold = 0;
   bit  req_gaps_on = 1'b1;
   bit  rsp_stalls_on = 1'b1;
   bit  req_held = 1'b0;

   // +/-18000 folding; both half-turn ends stay as they are
   function automatic int fold_cd(input int a);
      while (a > 18000) a -= 36000;
      while (a < -18000) a += 36000;
      return a;
   endfunction

   function automatic turn_outcome_type turn_outcome(input logic cmd, input logic dir,
                                                     input logic [7:0] spd,
                                                     input logic [15:0] ang,
                                                     input logic signed [15:0] yaw,
                                                     input logic [31:0] now);
      turn_outcome_type r;
      int            y, err, e, m, span, term, speed, nspd, sz, adiff;
      longint        num, den;
      logic [31:0]   elapsed;
      logic [2:0]    st;
      r = '0;
      y = fold_cd(int'(yaw));
      if (cmd == gtsc_pkg::CMD_START) begin
         // rejects leave any turn in progress alone
         if (spd == 8'd0) begin
            r.status = gtsc_pkg::ST_BAD_SPEED;
         end else if (ang == 16'd0) begin
            r.status = gtsc_pkg::ST_BAD_ANGLE;
         end else begin
            pr_turning   = 1'b1;
            pr_right     = dir;
            pr_top       = int'(spd);
            pr_start_yaw = y;
            pr_target    = fold_cd(dir ? y - int'(ang) : y + int'(ang));
            pr_prev_err  = fold_cd(pr_target - pr_start_yaw);
            pr_start_ms  = now;
            r.status     = gtsc_pkg::ST_STARTED;
         end
         return r;
      end
      if (!pr_turning) begin
         r.status = gtsc_pkg::ST_IDLE;
         return r;
      end
      err     = fold_cd(pr_target - y);
      e       = (err < 0) ? -err : err;
      m       = int'(cf_min_speed);
      span    = pr_top - m;
      sz      = int'(cf_slow_zone);
      elapsed = now - pr_start_ms;
      // quadratic slow-down, truncated toward zero; span may be negative
      if (sz == 0 || e >= sz) begin
         term = span;
      end else begin
         num  = longint'(span) * e * e;
         den  = longint'(sz) * sz;
         term = int'(num / den);
      end
      speed = m + term;
      if (speed > pr_top) speed = pr_top;
      if (speed < m) speed = m;

      if (e <= int'(cf_stop_band)) begin
         st = gtsc_pkg::ST_REACHED;
      end else if ((pr_prev_err > 0 && err < 0) || (pr_prev_err < 0 && err > 0)) begin
         st = gtsc_pkg::ST_OVERSHOOT;
      end else if (elapsed > {16'd0, cf_timeout}) begin
         st = gtsc_pkg::ST_TIMEOUT;
      end else begin
         st = gtsc_pkg::ST_DRIVING;
      end
      r.status = st;
      if (st == gtsc_pkg::ST_DRIVING) begin
         pr_prev_err = err;
         nspd        = -speed;
         r.left      = pr_right ? speed[8:0] : nspd[8:0];
         r.right     = pr_right ? nspd[8:0] : speed[8:0];
      end else begin
         // the stopping sample counts as the final yaw
         pr_turning = 1'b0;
         adiff      = fold_cd(y - pr_start_yaw);
         if (adiff < 0) adiff = -adiff;
         r.angle    = adiff[14:0];
         r.elapsed  = elapsed;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Response side: random back-pressure and the field-by-field checker
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (rsp_hold != 0) begin
         rsp_hold  <= rsp_hold - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_stalls_on && $urandom_range(0, 4) == 0) begin
         // stall: ready goes low and stays low while rsp_hold counts down
         rsp_hold  <= $urandom_range(0, 2);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic void check_field(input string name, input longint want,
                                       input longint got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      turn_outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_outcomes.size() == 0) begin
            $display("%0t ns: response with nothing expected, expected none, actual status %0d",
                     $time, rsp_status);
            fail_count++;
         end else begin
            want = due_outcomes.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("left_drive", $signed(want.left), rsp_left_drive);
            check_field("right_drive", $signed(want.right), rsp_right_drive);
            check_field("swept_angle", want.angle, rsp_swept_angle);
            check_field("time_taken", want.elapsed, rsp_time_taken);
         end
         status_seen[rsp_status]++;
      end
   end

   // watchdog: any transaction on any channel restarts the count
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("gyro_turn_speed_controller regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // One request transaction. Valid is left high on return so back-to-back
   // sends never drop it; a gap or drain() lowers it.
   task automatic send_req(input logic cmd, input logic dir, input logic [7:0] spd,
                           input logic [15:0] ang, input logic signed [15:0] yaw,
                           input logic [31:0] now);
      int gap;
      gap = (req_gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      if (gap > 0) begin
         if (req_held) begin
            req_valid <= 1'b0;
            req_held = 1'b0;
         end
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_held        = 1'b1;
      req_cmd        <= cmd;
      req_turn_dir   <= dir;
      req_speed      <= spd;
      req_turn_angle <= ang;
      req_yaw        <= yaw;
      req_now_ms     <= now;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      due_outcomes.push_back(turn_outcome(cmd, dir, spd, ang, yaw, now));
      sent_count++;
   endtask

   // drop valid and wait for every outstanding response
   task automatic drain();
      if (req_held) begin
         req_valid <= 1'b0;
         req_held = 1'b0;
      end
      while (due_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [gtsc_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [gtsc_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         gtsc_pkg::CSR_MIN_TURN_SPEED: cf_min_speed = data[7:0];
         gtsc_pkg::CSR_SLOW_ZONE:      cf_slow_zone = data[14:0];
         gtsc_pkg::CSR_STOP_BAND:      cf_stop_band = data[14:0];
         gtsc_pkg::CSR_TIMEOUT_MS:     cf_timeout   = data;
         default: begin
         end
      endcase
   endtask

   // full register load; only ever done with the block idle
   task automatic write_config(input logic [7:0] min_spd, input logic [15:0] slow,
                               input logic [15:0] stop, input logic [15:0] tmo);
      drain();
      write_reg(gtsc_pkg::CSR_MIN_TURN_SPEED, {8'd0, min_spd});
      write_reg(gtsc_pkg::CSR_SLOW_ZONE, slow);
      write_reg(gtsc_pkg::CSR_STOP_BAND, stop);
      write_reg(gtsc_pkg::CSR_TIMEOUT_MS, tmo);
      csr_valid <= 1'b0;
      @(posedge clock);
      config_loads++;
   endtask

   task automatic random_config();
      logic [7:0]  mn;
      logic [15:0] sz, sb, tmo;
      case ($urandom_range(0, 5))
         0:       mn = 8'd0;
         1:       mn = 8'd255;
         default: mn = 8'($urandom_range(0, 90));
      endcase
      case ($urandom_range(0, 7))
         0:       sz = 16'd0;
         1:       sz = 16'd1;
         2:       sz = 16'd18000;
         3:       sz = 16'($urandom);          // upper bit is dropped by the block
         default: sz = 16'($urandom_range(300, 8000));
      endcase
      case ($urandom_range(0, 9))
         0:       sb = 16'd0;
         1:       sb = 16'd18000;
         2:       sb = 16'($urandom);
         default: sb = 16'($urandom_range(1, 400));
      endcase
      case ($urandom_range(0, 7))
         0:       tmo = 16'd0;
         1:       tmo = 16'd65535;
         default: tmo = 16'($urandom_range(300, 8000));
      endcase
      write_config(mn, sz, sb, tmo);
   endtask

   // every field at random, in-range angle, raw 16-bit yaw
   task automatic noise_item();
      send_req(logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)), 8'($urandom),
               16'($urandom_range(0, 36000)), 16'($urandom), $urandom);
   endtask

   // A start followed by samples that sweep toward the target with jitter,
   // occasional sensor noise and out-of-range aliases of the same heading.
   task automatic random_turn();
      logic        dir;
      logic [7:0]  spd;
      logic [15:0] ang;
      logic [31:0] t;
      int          y0, prog, stride, jit, yv, dt_max;
      dir = 1'($urandom_range(0, 1));
      spd = ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      case ($urandom_range(0, 11))
         0:       ang = 16'd0;
         1:       ang = 16'd36000;
         2:       ang = 16'($urandom_range(1, 200));
         default: ang = 16'($urandom_range(1, 36000));
      endcase
      y0     = int'($urandom_range(0, 36000)) - 18000;
      t      = $urandom;
      dt_max = $urandom_range(1, 1500);
      send_req(gtsc_pkg::CMD_START, dir, spd, ang, 16'(y0), t);
      stride = int'(ang) / int'($urandom_range(2, 8)) + 1;
      prog   = 0;
      for (int k = 0; k < 16 && pr_turning; k++) begin
         jit  = int'($urandom_range(0, stride / 2)) - stride / 4;
         prog = prog + stride + jit;
         yv   = fold_cd(y0 + (dir ? -prog : prog));
         if ($urandom_range(0, 7) == 0) yv = fold_cd(yv + int'($urandom_range(0, 400)) - 200);
         if ($urandom_range(0, 5) == 0) begin
            if (yv >= 3232) yv -= 36000;
            else if (yv <= -3233) yv += 36000;
         end
         t = t + $urandom_range(0, dt_max);
         send_req(CMD_YAW, logic'($urandom_range(0, 1)), 8'($urandom),
                  16'($urandom_range(0, 36000)), 16'(yv), t);
      end
      // now and then a stray sample after the turn has ended
      if ($urandom_range(0, 5) == 0)
         send_req(CMD_YAW, 1'b0, 8'd0, 16'd0, 16'(y0), t);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // sample with no turn, zero speed (wins over zero angle), zero angle
   task automatic test_idle_and_rejects();
      send_req(CMD_YAW, 1'b0, 8'd50, 16'd100, 16'sd0, 32'd0);
      send_req(gtsc_pkg::CMD_START, 1'b0, 8'd0, 16'd0, 16'sd0, 32'd0);
      send_req(gtsc_pkg::CMD_START, 1'b1, 8'd255, 16'd0, 16'sd0, 32'd0);
   endtask

   // left turn at reset settings: full speed, slow zone, stop band;
   // a rejected start in the middle must not disturb the turn
   task automatic test_default_profile();
      send_req(gtsc_pkg::CMD_START, 1'b0, 8'd255, 16'd9000, 16'sd0, 32'd100);
      send_req(gtsc_pkg::CMD_START, 1'b0, 8'd0, 16'd500, 16'sd0, 32'd150);
      send_req(CMD_YAW, 1'b0, 8'd0, 16'd0, 16'sd1000, 32'd200);
      send_req(CMD_YAW, 1'b0, 8'd0, 16'd0, 16'sd7500, 32'd300);
      send_req(CMD_YAW, 1'b0, 8'd0, 16'd0, 16'sd8950, 32'd400);
   endtask

   // register extremes: floor above the requested speed, zero slow zone,
   // zero stop band and timeout, then the widest bands and timeout
   task automatic test_extreme_settings();
      write_config(8'd255, 16'd0, 16'd0, 16'd0);
      // full circle from an out-of-range yaw, time wrapping past 2^32
      send_req(gtsc_pkg::CMD_START, 1'b1, 8'd1, 16'd36000, 16'sd32767, 32'hFFFF_FFFF);
      send_req(CMD_YAW, 1'b0, 8'd0, 16'd0, -16'sd3000, 32'd0);
      send_req(gtsc_pkg::CMD_START, 1'b1, 8'd1, 16'd36000, 16'sd32767, 32'hFFFF_FFFF);
      send_req(CMD_YAW, 1'b0, 8'd0, 16'd0, -16'sd3000, 32'hFFFF_FFFF);
      send_req(CMD_YAW, 1'b0, 8'd0, 16'd0, -16'sd32768, 32'hFFFF_FFFF);
      send_req(CMD_YAW, 1'b0, 8'd0, 16'd0, -16'sd6000, 32'hFFFF_FFFF);

      // slow zone written with its unused top bit set
      write_config(8'd0, 16'h8000 | 16'd18000, 16'd18000, 16'd65535);
      send_req(gtsc_pkg::CMD_START, 1'b0, 8'd200, 16'd18000, -16'sd18000, 32'd0);
      send_req(CMD_YAW, 1'b0, 8'd0, 16'd0, 16'sd18000, 32'd65535);

      write_config(8'd10, 16'h7FFF, 16'd0, 16'd65535);
      send_req(gtsc_pkg::CMD_START, 1'b0, 8'd255, 16'd30000, 16'sd0, 32'd5);
      send_req(CMD_YAW, 1'b0, 8'd0, 16'd0, 16'sd0, 32'd65540);
      send_req(CMD_YAW, 1'b0, 8'd0, 16'd0, 16'sd100, 32'd65541);
   endtask

   // a new start replaces the turn in progress; one-centidegree turn
   // across the half-turn seam
   task automatic test_start_replaces_turn();
      send_req(gtsc_pkg::CMD_START, 1'b0, 8'd255, 16'd30000, 16'sd0, 32'd0);
      send_req(gtsc_pkg::CMD_START, 1'b1, 8'd128, 16'd1, -16'sd18000, 32'd7);
      send_req(CMD_YAW, 1'b0, 8'd0, 16'd0, 16'sd17999, 32'd9);
   endtask

   task automatic test_random_turns();
      int first;
      first = sent_count;
      random_config();
      while (sent_count - first < RANDOM_ITEMS) begin
         if ($urandom_range(0, 7) == 0) random_config();
         // some turns run with no idling at all
         req_gaps_on   = ($urandom_range(0, 3) != 0);
         rsp_stalls_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4)) noise_item();
         end else begin
            random_turn();
         end
      end
   endtask

   // back-to-back traffic with both sides always ready
   task automatic test_closing_burst();
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      write_config(8'd40, 16'd3000, 16'd100, 16'd5000);
      repeat (8) random_turn();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_and_rejects();
      test_default_profile();
      test_extreme_settings();
      test_start_replaces_turn();
      test_random_turns();
      test_closing_burst();

      drain();
      // let any stray response show up before the verdict
      repeat (24) @(posedge clock);

      $display("Covered %0d request transactions across %0d register loads plus reset values.",
               sent_count, config_loads);
      $display("Responses: started %0d, bad speed %0d, bad angle %0d, driving %0d,",
               status_seen[gtsc_pkg::ST_STARTED], status_seen[gtsc_pkg::ST_BAD_SPEED],
               status_seen[gtsc_pkg::ST_BAD_ANGLE], status_seen[gtsc_pkg::ST_DRIVING]);
      $display("  reached %0d, overshoot %0d, timeout %0d, idle sample %0d; %0d mismatches.",
               status_seen[gtsc_pkg::ST_REACHED], status_seen[gtsc_pkg::ST_OVERSHOOT],
               status_seen[gtsc_pkg::ST_TIMEOUT], status_seen[gtsc_pkg::ST_IDLE],
               fail_count);
      if (fail_count == 0) begin
         $display("gyro_turn_speed_controller regression: pass");
      end else begin
         $display("gyro_turn_speed_controller regression: fail");
      end
      $finish;
   end

endmodule
